@@ hw/rtl/sts_pkg.sv @@
// Shared types, constants and the probe-position function for the sorted table search.
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 32;
    localparam int POS_W       = 12;
    localparam int OUT_POS_W   = 11;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic        [ADDR_W-1:0] addr_t;
    typedef logic        [KEY_W-1:0]  key_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXACT = 2'd1,
        CMD_LOWER = 2'd2,
        CMD_UPPER = 2'd3
    } cmd_t;

    // Result of one probe step
    typedef struct packed {
        logic hit;
        logic cont;
        pos_t new_left;
        pos_t new_right;
        pos_t new_mid;
    } step_t;

    function automatic pos_t mid_of(input pos_t left, input pos_t right);
        pos_t diff;
        diff = right - left;
        return left + (diff >>> 1);
    endfunction

endpackage

@@ hw/rtl/sorted_table_search.sv @@
// Sorted table search: key table memory, probe sequencer and result register.
// A write is stored when it is accepted; a query passes through ST_START, one ST_SEARCH step per probe,
// an ST_CHECK step for the final check of a lower-bound search, and ST_DONE.
// One probe per cycle: the table memory's single registered read port feeds the probe unit.
// One query is in flight at a time; the next item is taken while a result waits on m_.
// Reset (aresetn low, synchronous) clears the sequencer and the result valid; table undefined.
module sorted_table_search
    import sts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] entry_index, [41:10] key_value, [52:42] range_left, [64:53] range_right
    input  logic [71:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] position
    output logic [15:0] m_tdata,
    // [0] found
    output logic        m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    localparam pos_t LAST_POS = pos_t'(TABLE_DEPTH - 1);
    localparam pos_t END_POS  = pos_t'(TABLE_DEPTH);

    state_t state_reg, state_next;
    cmd_t   mode_reg, mode_next;
    pos_t   left_reg, left_next;
    pos_t   right_reg, right_next;
    pos_t   mid_reg, mid_next;
    pos_t   end_reg, end_next;
    key_t   key_reg, key_next;
    logic   res_found_reg, res_found_next;
    pos_t   res_pos_reg, res_pos_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   m_found_reg, m_found_next;
    logic [OUT_POS_W-1:0] m_pos_reg, m_pos_next;

    key_t   key_mem [TABLE_DEPTH];
    key_t   rdata_reg;
    addr_t  rd_addr;

    cmd_t   in_cmd;
    addr_t  in_index;
    key_t   in_key;
    pos_t   in_left;
    pos_t   in_right;
    logic   s_accept;
    step_t  step;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_index = s_tdata[9:0];
    assign in_key   = s_tdata[41:10];
    assign in_left  = pos_t'({1'b0, s_tdata[52:42]});
    assign in_right = pos_t'(s_tdata[64:53]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    sts_step u_step (
        .mode  (mode_reg),
        .left  (left_reg),
        .right (right_reg),
        .mid   (mid_reg),
        .entry (rdata_reg),
        .key   (key_reg),
        .step  (step)
    );

    // Table memory: one write port from the input, one registered read port
    always_ff @(posedge aclk) begin
        if (s_accept && in_cmd == CMD_WRITE) begin
            key_mem[in_index] <= in_key;
        end
        rdata_reg <= key_mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        end_next       = end_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        rd_addr        = mid_reg[ADDR_W-1:0];
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_cmd != CMD_WRITE) begin
                    mode_next = in_cmd;
                    key_next  = in_key;
                    left_next = in_left;
                    if (in_cmd == CMD_UPPER) begin
                        if (in_right < pos_t'(0)) begin
                            right_next = pos_t'(0);
                        end else if (in_right > END_POS) begin
                            right_next = END_POS;
                        end else begin
                            right_next = in_right;
                        end
                    end else begin
                        right_next = (in_right > LAST_POS) ? LAST_POS : in_right;
                    end
                    end_next   = right_next;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                mid_next = mid_of(left_reg, right_reg);
                rd_addr  = mid_next[ADDR_W-1:0];
                res_found_next = 1'b0;
                res_pos_next   = pos_t'(0);
                case (mode_reg)
                    CMD_EXACT: begin
                        state_next = (left_reg <= right_reg) ? ST_SEARCH : ST_DONE;
                    end
                    CMD_LOWER: begin
                        if (left_reg > right_reg) begin
                            state_next = ST_DONE;
                        end else if (left_reg < right_reg) begin
                            state_next = ST_SEARCH;
                        end else begin
                            rd_addr    = left_reg[ADDR_W-1:0];
                            state_next = ST_CHECK;
                        end
                    end
                    default: begin
                        if (left_reg < right_reg) begin
                            state_next = ST_SEARCH;
                        end else begin
                            res_found_next = 1'b1;
                            res_pos_next   = (left_reg >= end_reg) ? end_reg : left_reg;
                            state_next     = ST_DONE;
                        end
                    end
                endcase
            end
            ST_SEARCH: begin
                if (step.hit) begin
                    res_found_next = 1'b1;
                    res_pos_next   = mid_reg;
                    state_next     = ST_DONE;
                end else if (step.cont) begin
                    // advance to the next probe and issue its read now
                    left_next  = step.new_left;
                    right_next = step.new_right;
                    mid_next   = step.new_mid;
                    rd_addr    = step.new_mid[ADDR_W-1:0];
                end else begin
                    case (mode_reg)
                        CMD_LOWER: begin
                            left_next  = step.new_left;
                            rd_addr    = step.new_left[ADDR_W-1:0];
                            state_next = ST_CHECK;
                        end
                        CMD_UPPER: begin
                            res_found_next = 1'b1;
                            res_pos_next   = (step.new_left >= end_reg) ? end_reg
                                                                        : step.new_left;
                            state_next     = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (rdata_reg == key_reg) begin
                    res_found_next = 1'b1;
                    res_pos_next   = left_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_pos_next    = res_pos_reg[OUT_POS_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        mid_reg       <= mid_next;
        end_reg       <= end_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(16 - OUT_POS_W){1'b0}}, m_pos_reg};

    // Every probe lies inside the current search range
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> (mid_reg >= left_reg) && (mid_reg <= right_reg))
        else $error("probe position outside search range");

    // A miss reports position zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("not-found result with nonzero position");

    // A finished query never overwrites a result still waiting
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && m_tvalid_reg && !m_tready |=> state_reg == ST_DONE)
        else $error("result register overwritten");

    // Input side stays closed while a query is being worked on
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_cmd != CMD_WRITE |=> !s_tready)
        else $error("item accepted during a query");

endmodule

@@ hw/rtl/sts_step.sv @@
// Shared probe unit: one compare of a table entry against the key and the range update.
module sts_step
    import sts_pkg::*;
(
    input  cmd_t  mode,
    input  pos_t  left,
    input  pos_t  right,
    input  pos_t  mid,
    input  key_t  entry,
    input  key_t  key,
    output step_t step
);

    logic eq;
    logic lt;
    logic go_right;

    assign eq = (entry == key);
    assign lt = ($signed(entry) < $signed(key));

    always_comb begin
        step = '0;
        go_right = 1'b0;
        unique case (mode)
            CMD_EXACT: begin
                go_right       = lt;
                step.hit       = eq;
                step.new_left  = go_right ? pos_t'(mid + pos_t'(1)) : left;
                step.new_right = go_right ? right : pos_t'(mid - pos_t'(1));
                step.cont      = !eq && (step.new_left <= step.new_right);
            end
            CMD_LOWER: begin
                go_right       = lt;
                step.new_left  = go_right ? pos_t'(mid + pos_t'(1)) : left;
                step.new_right = go_right ? right : mid;
                step.cont      = (step.new_left < step.new_right);
            end
            CMD_UPPER: begin
                go_right       = lt || eq;
                step.new_left  = go_right ? pos_t'(mid + pos_t'(1)) : left;
                step.new_right = go_right ? right : mid;
                step.cont      = (step.new_left < step.new_right);
            end
            default: begin
                go_right       = 1'b0;
                step.new_left  = left;
                step.new_right = right;
                step.cont      = 1'b0;
            end
        endcase
        step.new_mid = mid_of(step.new_left, step.new_right);
    end

endmodule

@@ bench/sorted_table_search_test.sv @@
// Self-checking testbench for the sorted table search: writes, exact, lower- and upper-bound queries.
module sorted_table_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int SHOWN_MAX   = 10;

    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] position;
    } answer_t;

    class search_checker;
        int      keys_held [TABLE_DEPTH];
        bit      written [TABLE_DEPTH];
        answer_t answers_due [$];
        int      errors;

        function void flag(string msg);
            errors++;
            if (errors <= SHOWN_MAX) $display("%s", msg);
        endfunction

        // Read one entry; clear clean when the entry was never written.
        function int peek(int p, inout bit clean);
            if (p < 0 || p >= TABLE_DEPTH) return 0;
            if (!written[p]) clean = 1'b0;
            return keys_held[p];
        endfunction

        // Work out the answer of one query; return 1 if every probe hit a written entry.
        function bit search_outcome(cmd_t c, int key, int left, int right, output answer_t ans);
            bit clean;
            bit hit;
            int lo;
            int hi;
            int mid;
            int v;
            int endp;
            int pos;
            clean = 1'b1;
            hit   = 1'b0;
            pos   = 0;
            lo    = left;
            hi    = right;
            case (c)
                CMD_EXACT: begin
                    if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
                    while (lo <= hi && !hit) begin
                        mid = lo + (hi - lo) / 2;
                        v   = peek(mid, clean);
                        if (v == key) begin
                            hit = 1'b1;
                            pos = mid;
                        end else if (v < key) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid - 1;
                        end
                    end
                end
                CMD_LOWER: begin
                    if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
                    if (lo <= hi) begin
                        while (lo < hi) begin
                            mid = lo + (hi - lo) / 2;
                            if (peek(mid, clean) < key) lo = mid + 1;
                            else hi = mid;
                        end
                        if (peek(lo, clean) == key) begin
                            hit = 1'b1;
                            pos = lo;
                        end
                    end
                end
                CMD_UPPER: begin
                    if (hi < 0) hi = 0;
                    if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
                    endp = hi;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (peek(mid, clean) <= key) lo = mid + 1;
                        else hi = mid;
                    end
                    hit = 1'b1;
                    pos = (lo >= endp) ? endp : lo;
                end
                default: ;
            endcase
            ans.found    = hit;
            ans.position = pos[OUT_POS_W-1:0];
            return clean;
        endfunction

        function void note_item(cmd_t c, int idx, int key, int left, int right);
            answer_t ans;
            if (c == CMD_WRITE) begin
                keys_held[idx] = key;
                written[idx]   = 1'b1;
            end else begin
                void'(search_outcome(c, key, left, right, ans));
                answers_due.push_back(ans);
            end
        endfunction

        function void check_result(logic found, logic [OUT_POS_W-1:0] position);
            answer_t want;
            if (answers_due.size() == 0) begin
                flag($sformatf("result with no query outstanding: found=%0d position=%0d",
                               found, position));
                return;
            end
            want = answers_due.pop_front();
            if (found !== want.found || position !== want.position)
                flag($sformatf("mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                               want.found, want.position, found, position));
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [9:0] entry_index, [41:10] key_value, [52:42] range_left, [64:53] range_right
    logic [71:0] s_tdata  = '0;
    // [1:0] cmd
    logic [1:0]  s_tuser  = CMD_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [10:0] position
    logic [15:0] m_tdata;
    // [0] found
    logic        m_tuser;

    search_checker sb = new();
    int sent;
    bit src_idle_on;
    bit sink_idle_on;
    bit calm;

    sorted_table_search uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[OUT_POS_W-1:0]);
    end

    // Receiver: stall in bursts while sink idling is on, unless the run is in its calm tail.
    initial begin
        @(posedge aclk);
        forever begin
            if (sink_idle_on && !calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send(cmd_t c, int idx, int key, int left, int right);
        if (src_idle_on && !calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {7'b0, 12'(right), 11'(left), 32'(key), 10'(idx)};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(c, idx, key, left, right);
        sent++;
    endtask

    task automatic write_entry(int idx, int key);
        send(CMD_WRITE, idx, key, 0, 0);
    endtask

    task automatic query(cmd_t c, int key, int left, int right);
        send(c, $urandom_range(0, TABLE_DEPTH - 1), key, left, right);
    endtask

    // One set: write a run of entries (usually sorted), then query around it.
    task automatic run_set();
        int      n;
        int      base;
        int      nq;
        int      j;
        int      a;
        int      b;
        int      lo;
        int      hi;
        int      key;
        int      tries;
        int      pick;
        longint  cur;
        bit      jumbled;
        cmd_t    c;
        answer_t probe_ans;
        int      run_keys [$];

        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        n       = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        base    = $urandom_range(0, TABLE_DEPTH - n);
        jumbled = ($urandom_range(0, 9) == 0);
        pick    = $urandom_range(0, 7);
        if (pick == 0) cur = -64'sd2147483648;
        else if (pick == 1) cur = 64'sd2147483647 - $urandom_range(0, 5000);
        else cur = longint'(int'($urandom));

        for (j = 0; j < n; j++) begin
            if (jumbled) begin
                run_keys.push_back(int'($urandom));
            end else begin
                run_keys.push_back(int'(cur));
                case ($urandom_range(0, 3))
                    0: ;
                    1: cur += $urandom_range(1, 3);
                    2: cur += $urandom_range(1, 1000);
                    default: cur += $urandom_range(1, 1 << 28);
                endcase
                if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            end
            write_entry(base + j, run_keys[j]);
        end

        // Scatter a few stray writes now and then.
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
                write_entry($urandom_range(0, TABLE_DEPTH - 1), int'($urandom));

        nq = $urandom_range(4, 14);
        repeat (nq) begin
            c = cmd_t'($urandom_range(1, 3));
            j = $urandom_range(0, n - 1);
            pick = $urandom_range(0, 19);
            if (pick < 10) key = run_keys[j];
            else if (pick < 12) key = run_keys[j] + 1;
            else if (pick < 14) key = run_keys[j] - 1;
            else if (pick < 17) key = int'($urandom);
            else if (pick < 18) key = 32'sh8000_0000;
            else key = 32'sh7FFF_FFFF;

            tries = 0;
            do begin
                if (tries < 6 && $urandom_range(0, 9) < 3) begin
                    lo = $urandom_range(0, TABLE_DEPTH);
                    hi = int'($urandom_range(0, TABLE_DEPTH + 1)) - 1;
                end else begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(a, n - 1);
                    if ($urandom_range(0, 2) == 0) begin
                        a = 0;
                        b = n - 1;
                    end
                    lo = base + a;
                    hi = (c == CMD_UPPER) ? base + b + 1 : base + b;
                end
                tries++;
            end while (!sb.search_outcome(c, key, lo, hi, probe_ans));
            query(c, key, lo, hi);
        end
    endtask

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        calm         = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Both ends of the table, with the key extremes and a duplicate.
        write_entry(0, 32'sh8000_0000);
        write_entry(1, -5);
        write_entry(2, 7);
        write_entry(3, 7);
        write_entry(1020, 100);
        write_entry(1021, 200);
        write_entry(1022, 300);
        write_entry(1023, 32'sh7FFF_FFFF);
        query(CMD_EXACT, -5, 0, 3);
        query(CMD_EXACT, 8, 0, 3);
        query(CMD_LOWER, 7, 0, 3);
        query(CMD_UPPER, 7, 0, 4);
        query(CMD_UPPER, 32'sh8000_0000, 0, 4);
        // Range ends past the table saturate.
        query(CMD_EXACT, 32'sh7FFF_FFFF, 1020, 1024);
        query(CMD_LOWER, 32'sh7FFF_FFFF, 1020, 1024);
        query(CMD_UPPER, 250, 1021, 1024);
        // Empty, negative and inverted ranges.
        query(CMD_UPPER, 0, 1024, 1024);
        query(CMD_UPPER, 0, 0, -1);
        query(CMD_UPPER, 0, 5, 2);
        query(CMD_EXACT, 7, 3, 1);
        query(CMD_LOWER, 7, 0, -1);
        query(CMD_EXACT, 32'sh7FFF_FFFF, 1024, 1024);
        // Break the order and search anyway.
        write_entry(4, -100);
        query(CMD_EXACT, -100, 0, 4);
        query(CMD_LOWER, -100, 0, 4);
        query(CMD_UPPER, 0, 0, 5);

        while (sent < ITEM_TARGET) begin
            if (sent > ITEM_TARGET * 85 / 100) calm = 1'b1;
            run_set();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
